// ----- sv/gmd_pkg.sv -----
// Shared types, constants and control-word layout for the grid maze path search.
package gmd_pkg;

    // Grid size: both limited to eight; the four-bit fields could hold up to fifteen.
    localparam int MAX_ROWS   = 8;
    localparam int MAX_COLS   = 8;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int CELL_W     = ROW_W + COL_W;
    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);
    localparam int FIELD_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 3'd0,
        CFG_COL_COUNT = 3'd1,
        CFG_START_ROW = 3'd2,
        CFG_START_COL = 3'd3,
        CFG_END_ROW   = 3'd4,
        CFG_END_COL   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [FIELD_W-1:0] row_count;
        logic [FIELD_W-1:0] col_count;
        logic [FIELD_W-1:0] start_row;
        logic [FIELD_W-1:0] start_col;
        logic [FIELD_W-1:0] end_row;
        logic [FIELD_W-1:0] end_col;
    } t_cfg;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    // Program steps of the sequencer.
    typedef enum logic [4:0] {
        S_IDLE  = 5'd0,
        S_CLR   = 5'd1,
        S_SRD   = 5'd2,
        S_SCHK  = 5'd3,
        S_PUSHS = 5'd4,
        S_TOP   = 5'd5,
        S_PROBE = 5'd6,
        S_DEC   = 5'd7,
        S_PUSH  = 5'd8,
        S_NDIR  = 5'd9,
        S_POP   = 5'd10,
        S_PLD   = 5'd11,
        S_OINIT = 5'd12,
        S_OLD   = 5'd13,
        S_OWAIT = 5'd14,
        S_ONEXT = 5'd15,
        S_NF    = 5'd16
    } t_step;

    typedef enum logic [3:0] {
        COND_ALWAYS    = 4'd0,
        COND_GO        = 4'd1,
        COND_IDX_LAST  = 4'd2,
        COND_START_BAD = 4'd3,
        COND_AT_GOAL   = 4'd4,
        COND_CAN_MOVE  = 4'd5,
        COND_DIR_LAST  = 4'd6,
        COND_SP_ONE    = 4'd7,
        COND_OUT_STALL = 4'd8,
        COND_OUT_LAST  = 4'd9
    } t_cond;

    typedef enum logic [1:0] {
        IDX_HOLD = 2'd0,
        IDX_CLR  = 2'd1,
        IDX_INC  = 2'd2
    } t_idx_op;

    typedef enum logic [1:0] {
        PUSH_NONE  = 2'd0,
        PUSH_START = 2'd1,
        PUSH_NB    = 2'd2
    } t_push_op;

    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_CLR  = 2'd1,
        DIR_INC  = 2'd2
    } t_dir_op;

    typedef enum logic {
        WRA_START = 1'b0,
        WRA_NB    = 1'b1
    } t_wra;

    typedef enum logic [1:0] {
        SRA_ZERO = 2'd0,
        SRA_POP  = 2'd1,
        SRA_IDX  = 2'd2
    } t_sra;

    typedef enum logic [1:0] {
        OUT_NONE = 2'd0,
        OUT_PATH = 2'd1,
        OUT_NF   = 2'd2
    } t_out_op;

    typedef struct packed {
        logic     in_rdy;
        t_idx_op  idx_op;
        logic     clr_vis;
        t_push_op push;
        logic     pop;
        logic     load_top;
        t_dir_op  dir_op;
        t_wra     wra;
        t_sra     sra;
        t_out_op  out_op;
        t_cond    cond;
        t_step    tgt_t;
        t_step    tgt_f;
    } t_ctrl;

    typedef struct packed {
        logic go;
        logic idx_last;
        logic start_bad;
        logic at_goal;
        logic can_move;
        logic dir_last;
        logic sp_one;
        logic out_stall;
        logic out_last;
    } t_stat;

endpackage

// ----- sv/gmd_in_if.sv -----
// Load channel: one grid cell wall bit per beat.
interface gmd_in_if import gmd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] cell_row;
    logic [FIELD_W-1:0] cell_col;
    logic               is_wall;
    logic               last_cell;

    modport source (output valid, output cell_row, output cell_col, output is_wall,
                    output last_cell, input ready);
    modport sink   (input valid, input cell_row, input cell_col, input is_wall,
                    input last_cell, output ready);
endinterface

// ----- sv/gmd_out_if.sv -----
// Result channel: one path cell or the not-found marker per beat.
interface gmd_out_if import gmd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] step_row;
    logic [FIELD_W-1:0] step_col;
    logic               path_found;
    logic               last_step;

    modport source (output valid, output step_row, output step_col, output path_found,
                    output last_step, input ready);
    modport sink   (input valid, input step_row, input step_col, input path_found,
                    input last_step, output ready);
endinterface

// ----- sv/gmd_seq.sv -----
// Microcode sequencer: step counter, control ROM and conditional jumps.
module gmd_seq import gmd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    function automatic t_ctrl rom_word(input t_step s);
        t_ctrl w;
        w = '0;
        unique case (s)
            S_IDLE: begin
                w.in_rdy = 1'b1;
                w.idx_op = IDX_CLR;
                w.cond   = COND_GO;
                w.tgt_t  = S_CLR;
                w.tgt_f  = S_IDLE;
            end
            S_CLR: begin
                w.clr_vis = 1'b1;
                w.idx_op  = IDX_INC;
                w.cond    = COND_IDX_LAST;
                w.tgt_t   = S_SRD;
                w.tgt_f   = S_CLR;
            end
            S_SRD: begin
                w.wra   = WRA_START;
                w.tgt_t = S_SCHK;
            end
            S_SCHK: begin
                w.cond  = COND_START_BAD;
                w.tgt_t = S_NF;
                w.tgt_f = S_PUSHS;
            end
            S_PUSHS: begin
                w.push  = PUSH_START;
                w.tgt_t = S_TOP;
            end
            S_TOP: begin
                w.dir_op = DIR_CLR;
                w.cond   = COND_AT_GOAL;
                w.tgt_t  = S_OINIT;
                w.tgt_f  = S_PROBE;
            end
            S_PROBE: begin
                w.wra   = WRA_NB;
                w.tgt_t = S_DEC;
            end
            S_DEC: begin
                w.cond  = COND_CAN_MOVE;
                w.tgt_t = S_PUSH;
                w.tgt_f = S_NDIR;
            end
            S_PUSH: begin
                w.push  = PUSH_NB;
                w.tgt_t = S_TOP;
            end
            S_NDIR: begin
                w.dir_op = DIR_INC;
                w.cond   = COND_DIR_LAST;
                w.tgt_t  = S_POP;
                w.tgt_f  = S_PROBE;
            end
            S_POP: begin
                w.pop   = 1'b1;
                w.sra   = SRA_POP;
                w.cond  = COND_SP_ONE;
                w.tgt_t = S_NF;
                w.tgt_f = S_PLD;
            end
            S_PLD: begin
                w.load_top = 1'b1;
                w.tgt_t    = S_TOP;
            end
            S_OINIT: begin
                w.idx_op = IDX_CLR;
                w.sra    = SRA_ZERO;
                w.tgt_t  = S_OLD;
            end
            S_OLD: begin
                w.out_op = OUT_PATH;
                w.idx_op = IDX_INC;
                w.tgt_t  = S_OWAIT;
            end
            S_OWAIT: begin
                w.cond  = COND_OUT_STALL;
                w.tgt_t = S_OWAIT;
                w.tgt_f = S_ONEXT;
            end
            S_ONEXT: begin
                w.sra   = SRA_IDX;
                w.cond  = COND_OUT_LAST;
                w.tgt_t = S_IDLE;
                w.tgt_f = S_OLD;
            end
            S_NF: begin
                w.out_op = OUT_NF;
                w.tgt_t  = S_OWAIT;
            end
            default: begin
                w.tgt_t = S_IDLE;
            end
        endcase
        return w;
    endfunction

    t_step r_step;
    t_step n_step;
    t_ctrl w_ctrl;
    logic  take;

    assign w_ctrl = rom_word(r_step);
    assign o_ctrl = w_ctrl;

    always_comb begin
        unique case (w_ctrl.cond)
            COND_ALWAYS:    take = 1'b1;
            COND_GO:        take = i_stat.go;
            COND_IDX_LAST:  take = i_stat.idx_last;
            COND_START_BAD: take = i_stat.start_bad;
            COND_AT_GOAL:   take = i_stat.at_goal;
            COND_CAN_MOVE:  take = i_stat.can_move;
            COND_DIR_LAST:  take = i_stat.dir_last;
            COND_SP_ONE:    take = i_stat.sp_one;
            COND_OUT_STALL: take = i_stat.out_stall;
            COND_OUT_LAST:  take = i_stat.out_last;
            default:        take = 1'b1;
        endcase
        n_step = take ? w_ctrl.tgt_t : w_ctrl.tgt_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- sv/gmd_dp.sv -----
// Search datapath: wall, visited and stack memories, cursor, counters and result register.
module gmd_dp import gmd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_ctrl            i_ctrl,
    gmd_in_if.sink           i_in,
    gmd_out_if.source        o_out,
    output t_stat            o_stat
);

    function automatic logic in_use(input logic [FIELD_W-1:0] r, c, er, ec);
        return (r != '0) && (c != '0) && (r <= er) && (c <= ec);
    endfunction

    function automatic logic [CELL_W-1:0] cell_of(input logic [FIELD_W-1:0] r, c);
        logic [FIELD_W-1:0] r0;
        logic [FIELD_W-1:0] c0;
        r0 = r - FIELD_W'(1);
        c0 = c - FIELD_W'(1);
        return {r0[ROW_W-1:0], c0[COL_W-1:0]};
    endfunction

    logic               r_wall_mem [CELL_COUNT];
    logic               r_vis_mem  [CELL_COUNT];
    logic [CELL_W-1:0]  r_stk_mem  [CELL_COUNT];

    logic               r_wall_q;
    logic               r_vis_q;
    logic [CELL_W-1:0]  r_stk_q;

    logic [CELL_W-1:0]  r_cur;
    logic [CELL_W-1:0]  n_cur;
    t_dir               r_dir;
    t_dir               n_dir;
    logic [DEPTH_W-1:0] r_sp;
    logic [DEPTH_W-1:0] n_sp;
    logic [DEPTH_W-1:0] r_idx;
    logic [DEPTH_W-1:0] n_idx;
    logic [CELL_W-1:0]  r_nb;
    logic               r_nb_ok;

    logic               r_o_valid;
    logic [FIELD_W-1:0] r_o_row;
    logic [FIELD_W-1:0] r_o_col;
    logic               r_o_found;
    logic               r_o_last;

    logic [FIELD_W-1:0] eff_rows;
    logic [FIELD_W-1:0] eff_cols;
    logic               start_ok;
    logic [CELL_W-1:0]  start_cell;
    logic               goal_ok;
    logic [CELL_W-1:0]  goal_cell;
    logic [FIELD_W-1:0] row1;
    logic [FIELD_W-1:0] col1;
    logic [FIELD_W-1:0] nr;
    logic [FIELD_W-1:0] nc;
    logic               nb_ok;
    logic [CELL_W-1:0]  nb_cell;
    logic               in_beat;
    logic               out_beat;
    logic               load_ok;
    logic [CELL_W-1:0]  load_cell;
    logic [CELL_W-1:0]  wall_ra;
    logic [CELL_W-1:0]  stk_ra;
    logic [DEPTH_W-1:0] sp_m2;

    // Counts above the grid size saturate.
    assign eff_rows = (i_cfg.row_count > FIELD_W'(MAX_ROWS)) ? FIELD_W'(MAX_ROWS)
                                                             : i_cfg.row_count;
    assign eff_cols = (i_cfg.col_count > FIELD_W'(MAX_COLS)) ? FIELD_W'(MAX_COLS)
                                                             : i_cfg.col_count;

    assign start_ok   = in_use(i_cfg.start_row, i_cfg.start_col, eff_rows, eff_cols);
    assign start_cell = cell_of(i_cfg.start_row, i_cfg.start_col);
    assign goal_ok    = in_use(i_cfg.end_row, i_cfg.end_col, eff_rows, eff_cols);
    assign goal_cell  = cell_of(i_cfg.end_row, i_cfg.end_col);

    // Neighbour of the current cell in the direction under test, one-based.
    assign row1 = FIELD_W'(r_cur[CELL_W-1:COL_W]) + FIELD_W'(1);
    assign col1 = FIELD_W'(r_cur[COL_W-1:0]) + FIELD_W'(1);

    always_comb begin
        nr = row1;
        nc = col1;
        unique case (r_dir)
            DIR_UP:    nr = row1 - FIELD_W'(1);
            DIR_DOWN:  nr = row1 + FIELD_W'(1);
            DIR_LEFT:  nc = col1 - FIELD_W'(1);
            DIR_RIGHT: nc = col1 + FIELD_W'(1);
            default:   nr = row1;
        endcase
    end

    assign nb_ok   = in_use(nr, nc, eff_rows, eff_cols);
    assign nb_cell = cell_of(nr, nc);

    assign in_beat   = i_in.valid & i_ctrl.in_rdy;
    assign out_beat  = r_o_valid & o_out.ready;
    assign load_ok   = (i_in.cell_row != '0) && (i_in.cell_row <= FIELD_W'(MAX_ROWS)) &&
                       (i_in.cell_col != '0) && (i_in.cell_col <= FIELD_W'(MAX_COLS));
    assign load_cell = cell_of(i_in.cell_row, i_in.cell_col);

    assign wall_ra = (i_ctrl.wra == WRA_START) ? start_cell : nb_cell;
    assign sp_m2   = r_sp - DEPTH_W'(2);

    always_comb begin
        unique case (i_ctrl.sra)
            SRA_ZERO: stk_ra = '0;
            SRA_POP:  stk_ra = sp_m2[CELL_W-1:0];
            SRA_IDX:  stk_ra = r_idx[CELL_W-1:0];
            default:  stk_ra = '0;
        endcase
    end

    // Wall map: written by load beats only.
    always_ff @(posedge i_clk) begin
        if (in_beat && load_ok) begin
            r_wall_mem[load_cell] <= i_in.is_wall;
        end
        r_wall_q <= r_wall_mem[wall_ra];
    end

    // Visited map: cleared by a sweep, then marked on each push.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr_vis) begin
            r_vis_mem[r_idx[CELL_W-1:0]] <= 1'b0;
        end else if (i_ctrl.push == PUSH_START) begin
            r_vis_mem[start_cell] <= 1'b1;
        end else if (i_ctrl.push == PUSH_NB) begin
            r_vis_mem[r_nb] <= 1'b1;
        end
        r_vis_q <= r_vis_mem[nb_cell];
    end

    // Path stack.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push == PUSH_START) begin
            r_stk_mem[0] <= start_cell;
        end else if (i_ctrl.push == PUSH_NB) begin
            r_stk_mem[r_sp[CELL_W-1:0]] <= r_nb;
        end
        r_stk_q <= r_stk_mem[stk_ra];
    end

    always_comb begin
        n_sp  = r_sp;
        n_cur = r_cur;
        unique case (i_ctrl.push)
            PUSH_START: begin
                n_sp  = DEPTH_W'(1);
                n_cur = start_cell;
            end
            PUSH_NB: begin
                n_sp  = r_sp + DEPTH_W'(1);
                n_cur = r_nb;
            end
            default: begin
                if (i_ctrl.pop) begin
                    n_sp = r_sp - DEPTH_W'(1);
                end
                if (i_ctrl.load_top) begin
                    n_cur = r_stk_q;
                end
            end
        endcase

        unique case (i_ctrl.dir_op)
            DIR_CLR: n_dir = DIR_UP;
            DIR_INC: n_dir = t_dir'(r_dir + 2'd1);
            default: n_dir = r_dir;
        endcase

        unique case (i_ctrl.idx_op)
            IDX_CLR: n_idx = '0;
            IDX_INC: n_idx = r_idx + DEPTH_W'(1);
            default: n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_cur     <= '0;
            r_dir     <= DIR_UP;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_sp  <= n_sp;
            r_cur <= n_cur;
            r_dir <= n_dir;
            r_idx <= n_idx;
            if (i_ctrl.out_op != OUT_NONE) begin
                r_o_valid <= 1'b1;
            end else if (out_beat) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload: neighbour latch and result register.
    always_ff @(posedge i_clk) begin
        r_nb    <= nb_cell;
        r_nb_ok <= nb_ok;
        unique case (i_ctrl.out_op)
            OUT_PATH: begin
                r_o_row   <= FIELD_W'(r_stk_q[CELL_W-1:COL_W]) + FIELD_W'(1);
                r_o_col   <= FIELD_W'(r_stk_q[COL_W-1:0]) + FIELD_W'(1);
                r_o_found <= 1'b1;
                r_o_last  <= (r_idx + DEPTH_W'(1)) == r_sp;
            end
            OUT_NF: begin
                r_o_row   <= '0;
                r_o_col   <= '0;
                r_o_found <= 1'b0;
                r_o_last  <= 1'b1;
            end
            default: begin
                r_o_row <= r_o_row;
            end
        endcase
    end

    assign i_in.ready       = i_ctrl.in_rdy;
    assign o_out.valid      = r_o_valid;
    assign o_out.step_row   = r_o_row;
    assign o_out.step_col   = r_o_col;
    assign o_out.path_found = r_o_found;
    assign o_out.last_step  = r_o_last;

    assign o_stat.go        = in_beat & i_in.last_cell;
    assign o_stat.idx_last  = r_idx == DEPTH_W'(CELL_COUNT - 1);
    assign o_stat.start_bad = !start_ok || r_wall_q;
    assign o_stat.at_goal   = goal_ok && (r_cur == goal_cell);
    assign o_stat.can_move  = r_nb_ok && !r_wall_q && !r_vis_q &&
                              (r_sp < DEPTH_W'(CELL_COUNT));
    assign o_stat.dir_last  = r_dir == DIR_RIGHT;
    assign o_stat.sp_one    = r_sp == DEPTH_W'(1);
    assign o_stat.out_stall = !out_beat;
    assign o_stat.out_last  = r_o_last;

`ifndef ASSERT_OFF
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= DEPTH_W'(CELL_COUNT))
        else $error("stack depth beyond grid size");

    a_no_load_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("load taken while a result is pending");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.push == PUSH_NB) |=> (r_sp == $past(r_sp) + DEPTH_W'(1)))
        else $error("push did not grow the stack");

    a_last_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_found && r_o_last) |-> (r_idx == r_sp))
        else $error("final path beat is not the stack top");
`endif

endmodule

// ----- sv/grid_maze_dfs_path.sv -----
// Top level of the grid maze depth-first path search.
//
// Usage: load the maze over i_in, one cell per beat (cell_row, cell_col one-based,
// is_wall). Loads are taken one per cycle while idle. The beat with last_cell
// high loads its cell and starts a search from the configured start cell to
// the end cell. Write the six configuration registers (row_count, col_count,
// start_row, start_col, end_row, end_col at indexes 0 to 5) over i_cfg_* only
// while idle. A search first sweeps the visited map clear, one cell a cycle,
// then runs a depth-first walk, neighbours tried up, down, left, right. A rejected
// neighbour goes through probe, decide and next direction, a taken one through
// probe, decide, push and goal test, and a dead end through pop, reload and goal
// test. The path leaves on o_out one cell per beat, start first, last_step on
// the goal cell; each cell is re-read from the stack, and the next is not offered
// until the last beat is taken. A failed search gives one beat with path_found
// low and row, col zero. i_in stays not ready from the last load until the final
// result beat is taken and the sequencer has passed its next-cell step back to
// idle; a stall on o_out simply holds the result register and sequencer.
// Reset (synchronous, active low) returns the sequencer to idle, empties the
// stack and restores the register defaults; the wall map keeps its contents.
module grid_maze_dfs_path import gmd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gmd_in_if.sink                i_in,
    gmd_out_if.source             o_out
);

    t_cfg  r_cfg;
    t_ctrl w_ctrl;
    t_stat w_stat;

    // Configuration registers; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count <= FIELD_W'(MAX_ROWS);
            r_cfg.col_count <= FIELD_W'(MAX_COLS);
            r_cfg.start_row <= FIELD_W'(1);
            r_cfg.start_col <= FIELD_W'(1);
            r_cfg.end_row   <= FIELD_W'(MAX_ROWS);
            r_cfg.end_col   <= FIELD_W'(MAX_COLS);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_COUNT: r_cfg.row_count <= i_cfg_data;
                CFG_COL_COUNT: r_cfg.col_count <= i_cfg_data;
                CFG_START_ROW: r_cfg.start_row <= i_cfg_data;
                CFG_START_COL: r_cfg.start_col <= i_cfg_data;
                CFG_END_ROW:   r_cfg.end_row   <= i_cfg_data;
                CFG_END_COL:   r_cfg.end_col   <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // Sequencer: steps through the search program.
    gmd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // Datapath: memories, cursor, stack pointer and result register.
    gmd_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctrl  (w_ctrl),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_stat  (w_stat)
    );

endmodule
